FILE: rtl/ihre_pkg.sv
// Shared constants, codes and types of the indexed min-heap priority engine.
package ihre_pkg;

	localparam int NODES     = 1024;
	localparam int EDGES     = 4096;
	localparam int DIST_W    = 32;
	localparam int NODE_W    = $clog2(NODES);
	localparam int SLOT_W    = $clog2(NODES + 2);
	localparam int EDGE_W    = $clog2(EDGES + 1);
	localparam int EDGE_IN_W = 12;
	localparam int COST_W    = 24;
	localparam int ACT_W     = 3;
	localparam int STAT_W    = 2;
	localparam int HSIZE_W   = 11;
	localparam int IN_W      = 2 * NODE_W + EDGE_IN_W + COST_W;
	localparam int IN_BYTES  = (IN_W + 7) / 8;
	localparam int OUT_W     = NODE_W + DIST_W + EDGE_W + HSIZE_W;
	localparam int OUT_BYTES = (OUT_W + 7) / 8;

	localparam logic [DIST_W-1:0] FAR       = '1;
	localparam logic [EDGE_W-1:0] EDGE_NONE = EDGE_W'(EDGES);
	localparam logic [SLOT_W-1:0] SCANNED   = SLOT_W'(NODES + 1);
	localparam logic [SLOT_W-1:0] UNSEEN    = '0;

	localparam logic [ACT_W-1:0] ACT_RESET   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SEED    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_RELAX   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_EXTRACT = 3'd3;

	localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd2;

	typedef struct packed {
		logic [SLOT_W-1:0] status;
		logic [DIST_W-1:0] distance;
		logic [EDGE_W-1:0] edge_id;
	} node_word_t;

	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] waddr;
		logic [NODE_W-1:0] wdata;
		logic [NODE_W-1:0] raddr;
	} heap_req_t;

	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] waddr;
		node_word_t        wdata;
		logic [NODE_W-1:0] raddr;
	} node_req_t;

endpackage

FILE: rtl/ihre_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ihre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/ihre_ctrl.sv
// Sequencer: decodes actions, walks sift-up and sift-down over the two RAMs, holds the result.
module ihre_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ihre_pkg::IN_BYTES*8-1:0]  s_tdata,
	input  logic [ihre_pkg::ACT_W-1:0]       s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ihre_pkg::OUT_BYTES*8-1:0] m_tdata,
	output logic [ihre_pkg::STAT_W-1:0]      m_tuser,
	output ihre_pkg::heap_req_t           hreq,
	input  logic [ihre_pkg::NODE_W-1:0]      heap_rdata,
	output ihre_pkg::node_req_t           nreq,
	input  ihre_pkg::node_word_t          node_rdata
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_FETCH, S_RFROM, S_NODE,
		S_U0, S_U1, S_U2,
		S_D0, S_D1, S_D2, S_D3,
		S_X1, S_X2, S_X3,
		S_PLACE, S_SCAN, S_OUT
	} state_t;

	localparam int NW = ihre_pkg::NODE_W;
	localparam int SW = ihre_pkg::SLOT_W;
	localparam int DW = ihre_pkg::DIST_W;
	localparam int EW = ihre_pkg::EDGE_W;
	localparam int IN_W_HI = ihre_pkg::IN_W - 1;

	state_t state_q;

	logic [NW-1:0]                   clr_q;
	logic [ihre_pkg::ACT_W-1:0]      act_q;
	logic [NW-1:0]                   n_q, from_q;
	logic [EW-1:0]                   edge_q;
	logic [ihre_pkg::COST_W-1:0]     cost_q;
	logic [DW-1:0]                   sum_q;
	logic [SW-1:0]                   count_q, j_q;
	logic [NW-1:0]                   x_q, p_q, a_q, b_q, r_q;
	logic [DW-1:0]                   d_q;
	logic [EW-1:0]                   e_q;
	ihre_pkg::node_word_t            wa_q;
	logic                            has_b_q;
	logic [NW-1:0]                   res_node_q;
	logic [DW-1:0]                   res_dist_q;
	logic [EW-1:0]                   res_edge_q;
	logic [ihre_pkg::STAT_W-1:0]     res_stat_q;
	logic                            m_valid_q;
	logic [ihre_pkg::OUT_BYTES*8-1:0] m_data_q;
	logic [ihre_pkg::STAT_W-1:0]     m_user_q;

	logic [ihre_pkg::EDGE_IN_W-1:0]  in_edge;
	logic [EW-1:0]                   in_edge_map;
	logic [DW:0]                     sum_full;
	logic [DW-1:0]                   sum_sat;
	logic                            queued;
	logic                            relax_ok;
	logic [SW:0]                     c_slot;
	logic                            pick_b;
	logic [NW-1:0]                   ch_node;
	ihre_pkg::node_word_t            ch_word;
	logic [SW-1:0]                   ch_slot;
	logic                            out_free;

	assign in_edge     = s_tdata[2*NW+ihre_pkg::EDGE_IN_W-1:2*NW];
	assign in_edge_map = ({{(EW-ihre_pkg::EDGE_IN_W){1'b0}}, in_edge} >= ihre_pkg::EDGE_NONE)
		? ihre_pkg::EDGE_NONE : {{(EW-ihre_pkg::EDGE_IN_W){1'b0}}, in_edge};

	assign sum_full = {1'b0, node_rdata.distance} + {{(DW+1-ihre_pkg::COST_W){1'b0}}, cost_q};
	assign sum_sat  = sum_full[DW] ? ihre_pkg::FAR : sum_full[DW-1:0];

	assign queued   = (node_rdata.status != ihre_pkg::UNSEEN) && (node_rdata.status <= count_q);
	assign relax_ok = (node_rdata.status != ihre_pkg::SCANNED) && (sum_q < node_rdata.distance);

	assign c_slot  = {j_q, 1'b0};
	assign pick_b  = has_b_q && (node_rdata.distance < wa_q.distance);
	assign ch_node = pick_b ? b_q : a_q;
	assign ch_word = pick_b ? node_rdata : wa_q;
	assign ch_slot = pick_b ? SW'(c_slot + 1'b1) : SW'(c_slot);

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	// RAM request decode
	always_comb begin
		hreq = '0;
		nreq = '0;
		case (state_q)
			S_CLEAR: begin
				nreq.we    = 1'b1;
				nreq.waddr = clr_q;
				nreq.wdata = '{status: ihre_pkg::UNSEEN, distance: ihre_pkg::FAR,
				               edge_id: ihre_pkg::EDGE_NONE};
			end
			S_FETCH: begin
				hreq.raddr = NW'(1);
				nreq.raddr = (act_q == ihre_pkg::ACT_RELAX) ? from_q : n_q;
			end
			S_RFROM: nreq.raddr = n_q;
			S_NODE: begin
				nreq.waddr = n_q;
				if (act_q == ihre_pkg::ACT_RESET && !queued) begin
					nreq.we    = 1'b1;
					nreq.wdata = '{status: ihre_pkg::UNSEEN, distance: ihre_pkg::FAR,
					               edge_id: ihre_pkg::EDGE_NONE};
				end else if ((act_q == ihre_pkg::ACT_SEED ||
				              (act_q == ihre_pkg::ACT_RELAX && relax_ok)) && !queued &&
				             count_q >= SW'(ihre_pkg::NODES)) begin
					nreq.we    = 1'b1;
					nreq.wdata = '{status: node_rdata.status,
					               distance: (act_q == ihre_pkg::ACT_SEED) ? '0 : sum_q,
					               edge_id: (act_q == ihre_pkg::ACT_SEED)
					                        ? ihre_pkg::EDGE_NONE : edge_q};
				end
			end
			S_U0: hreq.raddr = NW'(j_q >> 1);
			S_U1: nreq.raddr = heap_rdata;
			S_U2: begin
				if (node_rdata.distance > d_q) begin
					hreq.we    = 1'b1;
					hreq.waddr = j_q[NW-1:0];
					hreq.wdata = p_q;
					nreq.we    = 1'b1;
					nreq.waddr = p_q;
					nreq.wdata = '{status: j_q, distance: node_rdata.distance,
					               edge_id: node_rdata.edge_id};
				end
			end
			S_D0: hreq.raddr = c_slot[NW-1:0];
			S_D1: begin
				nreq.raddr = heap_rdata;
				hreq.raddr = NW'(c_slot + 1'b1);
			end
			S_D2: nreq.raddr = heap_rdata;
			S_D3: begin
				if (d_q > ch_word.distance) begin
					hreq.we    = 1'b1;
					hreq.waddr = j_q[NW-1:0];
					hreq.wdata = ch_node;
					nreq.we    = 1'b1;
					nreq.waddr = ch_node;
					nreq.wdata = '{status: j_q, distance: ch_word.distance,
					               edge_id: ch_word.edge_id};
				end
			end
			S_X1: begin
				nreq.raddr = heap_rdata;
				hreq.raddr = count_q[NW-1:0];
			end
			S_X2: nreq.raddr = heap_rdata;
			S_PLACE: begin
				hreq.we    = 1'b1;
				hreq.waddr = j_q[NW-1:0];
				hreq.wdata = x_q;
				nreq.we    = 1'b1;
				nreq.waddr = x_q;
				nreq.wdata = '{status: j_q, distance: d_q, edge_id: e_q};
			end
			S_SCAN: begin
				nreq.we    = 1'b1;
				nreq.waddr = r_q;
				nreq.wdata = '{status: ihre_pkg::SCANNED, distance: res_dist_q,
				               edge_id: res_edge_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready && state_q != S_OUT) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						act_q   <= s_tuser;
						n_q     <= s_tdata[NW-1:0];
						from_q  <= s_tdata[2*NW-1:NW];
						edge_q  <= in_edge_map;
						cost_q  <= s_tdata[IN_W_HI:2*NW+ihre_pkg::EDGE_IN_W];
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					if (act_q == ihre_pkg::ACT_EXTRACT && count_q == '0) begin
						res_node_q <= '0;
						res_dist_q <= ihre_pkg::FAR;
						res_edge_q <= ihre_pkg::EDGE_NONE;
						res_stat_q <= ihre_pkg::STAT_EMPTY;
						state_q    <= S_OUT;
					end else begin
						res_node_q <= n_q;
						res_stat_q <= ihre_pkg::STAT_DONE;
						if (act_q == ihre_pkg::ACT_EXTRACT) begin
							state_q <= S_X1;
						end else if (act_q == ihre_pkg::ACT_RELAX) begin
							state_q <= S_RFROM;
						end else begin
							state_q <= S_NODE;
						end
					end
				end
				S_RFROM: begin
					sum_q   <= sum_sat;
					state_q <= S_NODE;
				end
				S_NODE: begin
					x_q <= n_q;
					if (act_q == ihre_pkg::ACT_RESET) begin
						d_q        <= ihre_pkg::FAR;
						e_q        <= ihre_pkg::EDGE_NONE;
						res_dist_q <= ihre_pkg::FAR;
						res_edge_q <= ihre_pkg::EDGE_NONE;
						j_q        <= node_rdata.status;
						state_q    <= queued ? S_D0 : S_OUT;
					end else if (act_q == ihre_pkg::ACT_SEED ||
					             (act_q == ihre_pkg::ACT_RELAX && relax_ok)) begin
						d_q        <= (act_q == ihre_pkg::ACT_SEED) ? '0 : sum_q;
						e_q        <= (act_q == ihre_pkg::ACT_SEED) ? ihre_pkg::EDGE_NONE : edge_q;
						res_dist_q <= (act_q == ihre_pkg::ACT_SEED) ? '0 : sum_q;
						res_edge_q <= (act_q == ihre_pkg::ACT_SEED) ? ihre_pkg::EDGE_NONE : edge_q;
						if (queued) begin
							j_q     <= node_rdata.status;
							state_q <= S_U0;
						end else if (count_q < SW'(ihre_pkg::NODES)) begin
							count_q <= count_q + 1'b1;
							j_q     <= count_q + 1'b1;
							state_q <= S_U0;
						end else begin
							state_q <= S_OUT;
						end
					end else begin
						res_dist_q <= node_rdata.distance;
						res_edge_q <= node_rdata.edge_id;
						if (act_q == ihre_pkg::ACT_RELAX) begin
							res_stat_q <= ihre_pkg::STAT_IGNORED;
						end
						state_q <= S_OUT;
					end
				end
				S_U0: begin
					state_q <= (j_q == SW'(1)) ? S_PLACE : S_U1;
				end
				S_U1: begin
					p_q     <= heap_rdata;
					state_q <= S_U2;
				end
				S_U2: begin
					// move the parent down into the hole, climb one level
					if (node_rdata.distance > d_q) begin
						j_q     <= j_q >> 1;
						state_q <= S_U0;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_D0: begin
					state_q <= (c_slot > {1'b0, count_q}) ? S_PLACE : S_D1;
				end
				S_D1: begin
					a_q     <= heap_rdata;
					has_b_q <= (c_slot + 1'b1) <= {1'b0, count_q};
					state_q <= S_D2;
				end
				S_D2: begin
					wa_q    <= node_rdata;
					b_q     <= heap_rdata;
					state_q <= S_D3;
				end
				S_D3: begin
					if (d_q > ch_word.distance) begin
						j_q     <= ch_slot;
						state_q <= S_D0;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_X1: begin
					r_q        <= heap_rdata;
					res_node_q <= heap_rdata;
					state_q    <= S_X2;
				end
				S_X2: begin
					res_dist_q <= node_rdata.distance;
					res_edge_q <= node_rdata.edge_id;
					x_q        <= heap_rdata;
					state_q    <= S_X3;
				end
				S_X3: begin
					// last slot becomes the root, then sink it
					d_q     <= node_rdata.distance;
					e_q     <= node_rdata.edge_id;
					count_q <= count_q - 1'b1;
					j_q     <= SW'(1);
					state_q <= S_D0;
				end
				S_PLACE: begin
					state_q <= (act_q == ihre_pkg::ACT_EXTRACT) ? S_SCAN : S_OUT;
				end
				S_SCAN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {{(ihre_pkg::OUT_BYTES*8-ihre_pkg::OUT_W){1'b0}},
						              count_q, res_edge_q, res_dist_q, res_node_q};
						m_user_q  <= res_stat_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/indexed_min_heap_relax_extract.sv
// Top level of the indexed min-heap priority engine: sequencer plus heap and node RAMs.
// One beat in, one beat out per action; the next input beat is taken only once the result
// of the previous one sits in the output register. After reset every entry of the node table
// is cleared before the first beat is taken. Query, reset of an unqueued node and an ignored
// relax walk no heap levels; an accepted seed or relax sifts the node up, and extract and
// reset of a queued node sift a node down. Each sift-up level costs a heap-slot read and a
// node-table read, each sift-down level two of each, through the one read port of each RAM.
// A stalled result beat holds the engine in its output state and keeps the input closed.
module indexed_min_heap_relax_extract (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// node[9:0], from_node[19:10], edge_id[31:20], edge_cost[55:32]
	input  logic [ihre_pkg::IN_BYTES*8-1:0]  s_tdata,
	// action[2:0]
	input  logic [ihre_pkg::ACT_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// out_node[9:0], out_dist[41:10], out_edge[54:42], heap_size[65:55], zeros above
	output logic [ihre_pkg::OUT_BYTES*8-1:0] m_tdata,
	// out_status[1:0]
	output logic [ihre_pkg::STAT_W-1:0]      m_tuser
);

	ihre_pkg::heap_req_t          hreq;
	ihre_pkg::node_req_t          nreq;
	logic [ihre_pkg::NODE_W-1:0]  heap_rdata;
	ihre_pkg::node_word_t         node_rdata;
	logic [$bits(ihre_pkg::node_word_t)-1:0] node_rbits;

	assign node_rdata = ihre_pkg::node_word_t'(node_rbits);

	ihre_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.hreq       (hreq),
		.heap_rdata (heap_rdata),
		.nreq       (nreq),
		.node_rdata (node_rdata)
	);

	// slot numbers 1..NODES, slot NODES folds onto address zero
	ihre_ram #(
		.WIDTH (ihre_pkg::NODE_W),
		.DEPTH (ihre_pkg::NODES)
	) u_heap_ram (
		.clk   (clk),
		.we    (hreq.we),
		.waddr (hreq.waddr),
		.wdata (hreq.wdata),
		.raddr (hreq.raddr),
		.rdata (heap_rdata)
	);

	ihre_ram #(
		.WIDTH ($bits(ihre_pkg::node_word_t)),
		.DEPTH (ihre_pkg::NODES)
	) u_node_ram (
		.clk   (clk),
		.we    (nreq.we),
		.waddr (nreq.waddr),
		.wdata (nreq.wdata),
		.raddr (nreq.raddr),
		.rdata (node_rbits)
	);

endmodule

FILE: rtl/ihre_checker.sv
// Port-level checker for the priority engine, bound to the top level.
module ihre_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [ihre_pkg::IN_BYTES*8-1:0]  s_tdata,
	input logic [ihre_pkg::ACT_W-1:0]       s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [ihre_pkg::OUT_BYTES*8-1:0] m_tdata,
	input logic [ihre_pkg::STAT_W-1:0]      m_tuser
);

	localparam int HS_LO = ihre_pkg::NODE_W + ihre_pkg::DIST_W + ihre_pkg::EDGE_W;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an action is in flight");

	a_empty_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ihre_pkg::STAT_EMPTY |->
		m_tdata[HS_LO+ihre_pkg::HSIZE_W-1:HS_LO] == '0 &&
		m_tdata[ihre_pkg::NODE_W+ihre_pkg::DIST_W-1:ihre_pkg::NODE_W] == ihre_pkg::FAR)
		else $error("empty extract with nonzero size or reached distance");

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[HS_LO+ihre_pkg::HSIZE_W-1:HS_LO] <= ihre_pkg::HSIZE_W'(ihre_pkg::NODES)
		&& m_tuser != 2'd3)
		else $error("heap size or status out of range");

endmodule

bind indexed_min_heap_relax_extract ihre_checker u_ihre_checker (.*);

FILE: test/tb.sv
// Self-checking bench for the indexed min-heap priority engine: a queue-fed driver and a monitor with a heap predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ihre_pkg::*;

	localparam logic [ACT_W-1:0] ACT_QUERY = 3'd4;
	localparam int LIMIT = 2_000_000;

	typedef struct packed {
		logic [ACT_W-1:0]     action;
		logic [COST_W-1:0]    cost;
		logic [EDGE_IN_W-1:0] edge_in;
		logic [NODE_W-1:0]    from;
		logic [NODE_W-1:0]    node;
	} beat_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [HSIZE_W-1:0] hsize;
		logic [EDGE_W-1:0]  edge_out;
		logic [DIST_W-1:0]  distance;
		logic [NODE_W-1:0]  node;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_BYTES*8-1:0] s_tdata = '0;
	logic [ACT_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_BYTES*8-1:0] m_tdata;
	logic [STAT_W-1:0] m_tuser;
	logic s_tready_q = 1'b0;

	indexed_min_heap_relax_extract u_dut (.*);

	always #1 clk = ~clk;

	// predictor state
	int unsigned slot_node [1:NODES];
	int unsigned nstat [NODES];
	logic [DIST_W-1:0] ndist [NODES];
	logic [EDGE_W-1:0] nedge [NODES];
	int unsigned hcount;

	beat_t   pending [$];
	result_t expected_results [$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 1'b0;
	bit stim_done = 1'b0;
	longint cycles = 0;

	function automatic void swap_slots(int unsigned a, int unsigned b);
		int unsigned t;
		t = slot_node[a];
		slot_node[a] = slot_node[b];
		slot_node[b] = t;
		nstat[slot_node[a]] = a;
		nstat[slot_node[b]] = b;
	endfunction

	function automatic void sift_up(int unsigned j);
		while (j > 1 && ndist[slot_node[j/2]] > ndist[slot_node[j]]) begin
			swap_slots(j / 2, j);
			j = j / 2;
		end
	endfunction

	function automatic void sift_down(int unsigned j);
		int unsigned c;
		forever begin
			c = 2 * j;
			if (c > hcount) break;
			if (c + 1 <= hcount && ndist[slot_node[c+1]] < ndist[slot_node[c]]) c++;
			if (ndist[slot_node[j]] > ndist[slot_node[c]]) begin
				swap_slots(j, c);
				j = c;
			end else break;
		end
	endfunction

	function automatic bit queued(int unsigned n);
		return nstat[n] >= 1 && nstat[n] <= hcount;
	endfunction

	function automatic void enqueue(int unsigned n);
		if (hcount < NODES) begin
			hcount++;
			slot_node[hcount] = n;
			nstat[n] = hcount;
		end
	endfunction

	function automatic result_t heap_step(beat_t b);
		result_t r;
		int unsigned n, res;
		logic [DIST_W:0] s;
		logic [EDGE_W-1:0] e;
		n = b.node;
		res = n;
		r.status = STAT_DONE;
		e = (b.edge_in >= EDGES) ? EDGE_NONE : EDGE_W'(b.edge_in);
		case (b.action)
		ACT_RESET: begin
			ndist[n] = FAR;
			nedge[n] = EDGE_NONE;
			if (queued(n)) sift_down(nstat[n]);
			else nstat[n] = 0;
		end
		ACT_SEED: begin
			ndist[n] = '0;
			nedge[n] = EDGE_NONE;
			if (!queued(n)) enqueue(n);
			if (queued(n)) sift_up(nstat[n]);
		end
		ACT_RELAX: begin
			s = {1'b0, ndist[b.from]} + b.cost;
			if (s > FAR) s = FAR;
			if (nstat[n] != NODES + 1 && s[DIST_W-1:0] < ndist[n]) begin
				ndist[n] = s[DIST_W-1:0];
				nedge[n] = e;
				if (!queued(n)) enqueue(n);
				if (queued(n)) sift_up(nstat[n]);
			end else r.status = STAT_IGNORED;
		end
		ACT_EXTRACT: begin
			if (hcount == 0) r.status = STAT_EMPTY;
			else begin
				res = slot_node[1];
				slot_node[1] = slot_node[hcount];
				hcount--;
				nstat[slot_node[1]] = 1;
				sift_down(1);
				nstat[res] = NODES + 1;
			end
		end
		default: ;
		endcase
		if (r.status == STAT_EMPTY) begin
			r.node = '0;
			r.distance = FAR;
			r.edge_out = EDGE_NONE;
		end else begin
			r.node = NODE_W'(res);
			r.distance = ndist[res];
			r.edge_out = nedge[res];
		end
		r.hsize = HSIZE_W'(hcount);
		return r;
	endfunction

	function automatic beat_t mk(logic [ACT_W-1:0] a, int unsigned n, int unsigned f,
			int unsigned e, int unsigned c);
		beat_t b;
		b.action = a;
		b.node = NODE_W'(n);
		b.from = NODE_W'(f);
		b.edge_in = EDGE_IN_W'(e);
		b.cost = COST_W'(c);
		return b;
	endfunction

	// random mix: mostly grow-and-extract over the given node pool (small in later phases), some noise
	function automatic beat_t rand_beat(int unsigned pool);
		int unsigned p;
		p = $urandom_range(99);
		if (p < 8) return mk(ACT_SEED, $urandom_range(pool), 0, 0, 0);
		if (p < 55) return mk(ACT_RELAX, $urandom_range(pool), $urandom_range(pool),
			$urandom, ($urandom_range(3) == 0) ? $urandom : $urandom_range(5000));
		if (p < 80) return mk(ACT_EXTRACT, $urandom, $urandom, $urandom, $urandom);
		if (p < 88) return mk(ACT_RESET, $urandom_range(pool), 0, 0, 0);
		if (p < 94) return mk(ACT_QUERY, $urandom_range(pool), 0, 0, 0);
		return mk(ACT_W'($urandom_range(7)), $urandom, $urandom, $urandom, $urandom);
	endfunction

	// driver: present beats at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				// beat taken at the last rising edge; queue already popped there
			end
			if (!s_tvalid || s_tready_q) begin
				if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= {{(IN_BYTES*8-IN_W){1'b0}}, pending[0].cost,
						pending[0].edge_in, pending[0].from, pending[0].node};
					s_tuser <= pending[0].action;
				end else s_tvalid <= 1'b0;
			end
			m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// acceptance seen at the rising edge
	always @(posedge clk) begin
		s_tready_q <= 1'b0;
		if (arst_n && s_tvalid && s_tready) begin
			expected_results.push_back(heap_step(pending.pop_front()));
			s_tready_q <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t got, want;
		cycles <= cycles + 1;
		if (arst_n && m_tvalid && m_tready) begin
			got.node = m_tdata[9:0];
			got.distance = m_tdata[41:10];
			got.edge_out = m_tdata[54:42];
			got.hsize = m_tdata[65:55];
			got.status = m_tuser;
			if (expected_results.size() == 0) begin
				$error("unexpected result beat node=%0d", got.node);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (got.node !== want.node) begin
					$error("out_node expected %0d got %0d", want.node, got.node); errors++;
				end
				if (got.distance !== want.distance) begin
					$error("out_dist expected %0d got %0d", want.distance, got.distance);
					errors++;
				end
				if (got.edge_out !== want.edge_out) begin
					$error("out_edge expected %0d got %0d", want.edge_out, got.edge_out);
					errors++;
				end
				if (got.status !== want.status) begin
					$error("out_status expected %0d got %0d", want.status, got.status);
					errors++;
				end
				if (got.hsize !== want.hsize) begin
					$error("heap_size expected %0d got %0d", want.hsize, got.hsize); errors++;
				end
			end
		end
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		int k;
		wait (arst_n === 1'b1 && pending.size() > 200);
		repeat (50) @(posedge clk);
		hold_off = 1'b1;
		for (k = 0; k < 400; k++) @(posedge clk);
		hold_off = 1'b0;
	end

	task automatic drain();
		while (pending.size() > 0 || expected_results.size() > 0) @(posedge clk);
	endtask

	initial begin
		int ph;
		for (int i = 0; i < NODES; i++) begin
			nstat[i] = 0;
			ndist[i] = FAR;
			nedge[i] = EDGE_NONE;
		end
		for (int i = 1; i <= NODES; i++) slot_node[i] = 0;
		hcount = 0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: empty extract, extremes, every action, ties, saturation, odd codes
		pending.push_back(mk(ACT_EXTRACT, 0, 0, 0, 0));
		pending.push_back(mk(ACT_QUERY, 1023, 0, 0, 0));
		pending.push_back(mk(ACT_SEED, 1023, 0, 0, 0));
		pending.push_back(mk(ACT_SEED, 0, 0, 0, 0));
		pending.push_back(mk(ACT_RELAX, 5, 1023, 4095, 24'hFFFFFF));
		pending.push_back(mk(ACT_RELAX, 6, 1023, 0, 24'hFFFFFF));
		pending.push_back(mk(ACT_RELAX, 5, 0, 17, 100));
		pending.push_back(mk(ACT_RELAX, 5, 0, 18, 100));
		pending.push_back(mk(ACT_RELAX, 7, 999, 1, 24'hFFFFFF));
		pending.push_back(mk(ACT_RESET, 6, 0, 0, 0));
		pending.push_back(mk(ACT_RESET, 700, 0, 0, 0));
		pending.push_back(mk(ACT_EXTRACT, 0, 0, 0, 0));
		pending.push_back(mk(ACT_RELAX, 1023, 0, 3, 9));
		pending.push_back(mk(ACT_EXTRACT, 0, 0, 0, 0));
		pending.push_back(mk(ACT_RELAX, 8, 1023, 4094, 0));
		pending.push_back(mk(ACT_SEED, 1023, 0, 0, 0));
		pending.push_back(mk(3'd5, 5, 0, 0, 0));
		pending.push_back(mk(3'd6, 8, 0, 0, 0));
		pending.push_back(mk(3'd7, 1023, 1023, 4095, 24'hFFFFFF));
		for (int i = 0; i < 6; i++) pending.push_back(mk(ACT_EXTRACT, 0, 0, 0, 0));
		drain();

		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 12 : 61) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 12 : 61) : 0;
			for (int i = 0; i < 270; i++)
				pending.push_back(rand_beat((ph == 0) ? 1023 : 63));
			drain();
		end
		repeat (100) @(posedge clk);
		stim_done = 1'b1;
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule

FILE: indexed_min_heap_relax_extract.f
rtl/ihre_pkg.sv
rtl/ihre_ram.sv
rtl/ihre_ctrl.sv
rtl/indexed_min_heap_relax_extract.sv
rtl/ihre_checker.sv
test/tb.sv
